/* hdl/dhip_pkg.sv */
// Shared types and character codes for the decimal/hex integer parser.
// No dependencies; imported by the design, checker and testbench modules.
package dhip_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int OUT_BITS       = 64;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       is_last;
  } dhip_beat_t;

endpackage

/* hdl/dhip_core.sv */
// Per-literal parse state and the single-character update step.
// Depends on dhip_pkg for character codes and the beat type.
module dhip_core
  import dhip_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  dhip_beat_t                  beat,
  output logic signed [OUT_BITS-1:0]  res_value,
  output logic                        res_ok
);

  localparam int VB = VALUE_BITS;
  localparam logic [VB-1:0] MAX_MAG = {1'b0, {(VB-1){1'b1}}};

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_PREFIX = 3'd4
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic          neg_r, neg_nxt;
  logic          hex_r, hex_nxt;
  logic [VB-1:0] mag_r, mag_nxt;
  logic          seen_r, seen_nxt;
  logic          sat_r, sat_nxt;
  logic          err_r, err_nxt;

  logic [7:0]    c;
  logic          is_dec, is_hlo, is_hup, dig_ok;
  logic [3:0]    dig;
  logic          take_digit;
  logic [VB+3:0] dec_prod;
  logic          ovf;
  logic [VB-1:0] mag_step;
  logic [VB-1:0] mag_neg;

  assign c      = beat.char_code;
  assign is_dec = (c >= CH_0) && (c <= CH_9);
  assign is_hlo = hex_r && (c >= CH_A_LO) && (c <= CH_F_LO);
  assign is_hup = hex_r && (c >= CH_A_UP) && (c <= CH_F_UP);
  assign dig_ok = is_dec || is_hlo || is_hup;

  always_comb begin
    priority if (is_dec) begin
      dig = 4'(c - CH_0);
    end else if (is_hlo) begin
      dig = 4'(c - CH_A_LO + 8'd10);
    end else begin
      dig = 4'(c - CH_A_UP + 8'd10);
    end
  end

  // mag*10 + d as two shifted copies; magnitude never exceeds MAX_MAG.
  assign dec_prod = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + (VB+4)'(dig);

  // Hex overflows once any of the four bits below the sign would shift into or past the sign.
  assign ovf = hex_r ? (|mag_r[VB-2:VB-5]) : (|dec_prod[VB+3:VB-1]);
  assign mag_step = hex_r ? {mag_r[VB-5:0], dig} : dec_prod[VB-1:0];

  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    hex_nxt    = hex_r;
    mag_nxt    = mag_r;
    seen_nxt   = seen_r;
    sat_nxt    = sat_r;
    err_nxt    = err_r;
    take_digit = 1'b0;
    if (step_en && beat.char_present && !err_r) begin
      unique case (phase_r)
        PH_START, PH_SIGN: begin
          priority if (phase_r == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
            neg_nxt   = (c == CH_MINUS);
            phase_nxt = PH_SIGN;
          end else if (c == CH_0) begin
            seen_nxt  = 1'b1;
            phase_nxt = PH_ZERO;
          end else begin
            take_digit = 1'b1;
          end
        end
        PH_ZERO: begin
          if (c == CH_X_LO || c == CH_X_UP) begin
            hex_nxt   = 1'b1;
            seen_nxt  = 1'b0;
            phase_nxt = PH_PREFIX;
          end else begin
            take_digit = 1'b1;
          end
        end
        PH_DIGITS, PH_PREFIX: begin
          take_digit = 1'b1;
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
      if (take_digit) begin
        if (!dig_ok) begin
          err_nxt = 1'b1;
        end else begin
          seen_nxt  = 1'b1;
          phase_nxt = PH_DIGITS;
          if (!sat_r) begin
            if (ovf) begin
              mag_nxt = MAX_MAG;
              sat_nxt = 1'b1;
            end else begin
              mag_nxt = mag_step;
            end
          end
        end
      end
    end
  end

  assign mag_neg   = neg_nxt ? (~mag_nxt + 1'b1) : mag_nxt;
  assign res_ok    = !err_nxt && seen_nxt;
  assign res_value = res_ok ? OUT_BITS'(signed'(mag_neg)) : '0;

  // Clear everything on reset or once the literal ends.
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && beat.is_last)) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      hex_r   <= 1'b0;
      mag_r   <= '0;
      seen_r  <= 1'b0;
      sat_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      hex_r   <= hex_nxt;
      mag_r   <= mag_nxt;
      seen_r  <= seen_nxt;
      sat_r   <= sat_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* hdl/decimal_hex_integer_parser_top.sv */
// Integer literal parser: input register, dhip_core step logic, result register.
// Depends on dhip_pkg and dhip_core.
//
// Usage: feed one character of a literal per beat on the in_ channel
// (in_char_code, in_char_present, in_is_last). A literal is an optional
// sign, an optional 0x/0X prefix, then digits of base 10 or 16. The beat
// with in_is_last high closes the literal and yields exactly one out_ beat:
// out_value (signed, sign-extended from VALUE_BITS, magnitude saturated at
// 2^(VALUE_BITS-1)-1) and out_valid_res. Invalid literals give zero.
// Other beats yield nothing.
// Timing: a beat accepted into the input register is processed by the step
// logic when it leaves; a closing beat's result is then registered.
// Throughput: one beat per cycle while in_stall is low; the per-character
// shift-add on the magnitude register is the only loop.
// Stall: when out_stall holds a result, the closing beat waits in the input
// register and in_stall rises; beats that do not close a literal keep flowing.
// Reset: synchronous, active low; clears both valid flags and parse state.
module decimal_hex_integer_parser_top
  import dhip_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_char_present,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_BITS-1:0]  out_value,
  output logic                        out_valid_res
);

  dhip_beat_t                  s1_r;
  logic                        s1_v_r;
  logic                        s1_adv;
  logic                        in_acc;
  logic                        out_free;
  logic                        out_v_r;
  logic signed [OUT_BITS-1:0]  out_value_r;
  logic                        out_ok_r;
  logic signed [OUT_BITS-1:0]  res_value;
  logic                        res_ok;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && (!s1_r.is_last || out_free);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  dhip_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (s1_adv),
    .beat     (s1_r),
    .res_value(res_value),
    .res_ok   (res_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv && s1_r.is_last) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers: load on accept or on a closing beat's advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.char_code    <= in_char_code;
      s1_r.char_present <= in_char_present;
      s1_r.is_last      <= in_is_last;
    end
    if (s1_adv && s1_r.is_last) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
    end
  end

  assign out_valid     = out_v_r;
  assign out_value     = out_value_r;
  assign out_valid_res = out_ok_r;

endmodule

/* hdl/dhip_checker.sv */
// Port-level checks for decimal_hex_integer_parser_top, attached by bind.
// Depends on dhip_pkg for the output width.
module dhip_checker
  import dhip_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [OUT_BITS-1:0]  out_value,
  input logic                        out_valid_res
);

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_valid_res))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_value == '0)
    else $error("invalid literal with nonzero value");

  a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_value != MOST_NEG)
    else $error("saturation passed the symmetric limit");

endmodule

bind decimal_hex_integer_parser_top dhip_checker u_dhip_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_value    (out_value),
  .out_valid_res(out_valid_res)
);

/* tb/sv/dhip_checker.sv */
// Watches the in_ and out_ channels of the integer literal parser, predicts each
// literal's value and valid flag, and compares them with the results that come out.
// Depends on dhip_pkg for the character codes.
module dhip_scoreboard
  import dhip_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [7:0]                 in_char_code,
  input  logic                       in_char_present,
  input  logic                       in_is_last,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [OUT_BITS-1:0] out_value,
  input  logic                       out_valid_res,
  output int                         mismatches,
  output int                         pending,
  output int                         results_seen,
  output int                         well_formed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    LIT_START, LIT_SIGN, LIT_ZERO, LIT_DIGITS, LIT_PREFIX
  } lit_phase_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               ok;
  } parsed_lit_t;

  parsed_lit_t parsed_q[$];

  lit_phase_t  phase;
  logic        neg, hexm, seen, sat, bad;
  logic [63:0] mag;

  task automatic clear_literal();
    phase = LIT_START;
    neg   = 1'b0;
    hexm  = 1'b0;
    seen  = 1'b0;
    sat   = 1'b0;
    bad   = 1'b0;
    mag   = '0;
  endtask

  function automatic int digit_of(logic [7:0] c, logic hx);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (hx && c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
    if (hx && c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
    return -1;
  endfunction

  task automatic accumulate(int d);
    logic [63:0] base, dv;
    base = hexm ? 64'd16 : 64'd10;
    dv   = 64'(d);
    seen = 1'b1;
    if (!sat) begin
      // clamp once the next shift-add would pass the largest magnitude
      if (mag > (MAG_MAX - dv) / base) begin
        mag = MAG_MAX;
        sat = 1'b1;
      end else begin
        mag = mag * base + dv;
      end
    end
  endtask

  task automatic absorb_char(logic [7:0] c);
    int d;
    if (bad) return;
    if (phase == LIT_START && (c == CH_PLUS || c == CH_MINUS)) begin
      neg   = (c == CH_MINUS);
      phase = LIT_SIGN;
      return;
    end
    if ((phase == LIT_START || phase == LIT_SIGN) && c == CH_0) begin
      seen  = 1'b1;
      phase = LIT_ZERO;
      return;
    end
    if (phase == LIT_ZERO && (c == CH_X_LO || c == CH_X_UP)) begin
      // the leading zero was a prefix, not a digit
      hexm  = 1'b1;
      seen  = 1'b0;
      phase = LIT_PREFIX;
      return;
    end
    d = digit_of(c, hexm);
    if (d < 0) begin
      bad = 1'b1;
    end else begin
      accumulate(d);
      phase = LIT_DIGITS;
    end
  endtask

  task automatic close_literal();
    parsed_lit_t p;
    p.ok    = !bad && seen;
    p.value = '0;
    if (p.ok) p.value = neg ? 64'd0 - mag : mag;
    parsed_q.push_back(p);
    clear_literal();
  endtask

  always @(posedge clk) begin
    parsed_lit_t want;
    if (!rst_n) begin
      clear_literal();
      parsed_q.delete();
      mismatches   = 0;
      results_seen = 0;
      well_formed  = 0;
    end else begin
      // compare first so a beat closing at this edge never meets its own result
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_valid_res === 1'b1) well_formed++;
        if (parsed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: unexpected result value=%0d valid_res=%b",
                     $realtime, out_value, out_valid_res);
        end else begin
          want = parsed_q.pop_front();
          if (out_value !== want.value || out_valid_res !== want.ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: result mismatch: value exp %0d got %0d, valid_res exp %b got %b",
                       $realtime, want.value, out_value, want.ok, out_valid_res);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_char_present) absorb_char(in_char_code);
        if (in_is_last) close_literal();
      end
    end
    pending <= parsed_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// Top of the integer literal parser testbench: clock, reset, literal stimulus,
// random idling on both channels and the verdict. Depends on dhip_pkg,
// dhip_scoreboard and decimal_hex_integer_parser_top.
module tb
  import dhip_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 650;
  localparam int CYCLE_LIMIT = 200000;

  typedef byte unsigned chars_t[$];

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_char_code    = 8'h00;
  logic                       in_char_present = 1'b0;
  logic                       in_is_last      = 1'b0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic signed [OUT_BITS-1:0] out_value;
  logic                       out_valid_res;

  int mismatches, pending, results_seen, well_formed;
  int send_idle_pct  = 26;
  int recv_stall_pct = 82;
  int chars_sent     = 0;
  int lits_sent      = 0;
  int cycles         = 0;

  string probes[8] = '{"+", "0x", "-7", "+0", "0XaF", "--1", "0xx", " 5"};
  string limit_lits[7] = '{"9223372036854775807", "9223372036854775808",
                           "-9223372036854775808", "0x7fffffffffffffff",
                           "-0x8000000000000000", "0XFFFFFFFFFFFFFFFFF",
                           "99999999999999999999"};

  decimal_hex_integer_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_char_present (in_char_present),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_valid_res   (out_valid_res)
  );

  dhip_scoreboard u_sb (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_char_present (in_char_present),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_valid_res   (out_valid_res),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_seen    (results_seen),
    .well_formed     (well_formed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_beat(logic [7:0] code, logic present, logic last);
    int gaps;
    gaps = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gaps < 20) gaps++;
    repeat (gaps) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_char_code    <= code;
    in_char_present <= present;
    in_is_last      <= last;
    do @(posedge clk); while (in_stall);
    if (present) chars_sent++;
    if (last) lits_sent++;
  endtask

  task automatic send_lit(chars_t q, bit sprinkle);
    bit split_end;
    split_end = sprinkle && ($urandom_range(0, 9) == 0);
    if (q.size() == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < q.size(); i++) begin
      if (sprinkle && $urandom_range(0, 19) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(q[i], 1'b1, !split_end && i == q.size() - 1);
    end
    // close with a beat that carries no character
    if (split_end) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic chars_t to_chars(string s);
    chars_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic chars_t make_literal();
    chars_t q;
    int     pick, flaw, n, d;
    bit     hx;
    pick = $urandom_range(0, 99);
    if (pick < 3) return to_chars(limit_lits[$urandom_range(0, 6)]);
    flaw = (pick < 68) ? 0 : $urandom_range(1, 6);
    case ($urandom_range(0, 2))
      1: q.push_back(CH_PLUS);
      2: q.push_back(CH_MINUS);
      default: ;
    endcase
    hx = 1'($urandom_range(0, 1));
    if (hx) begin
      q.push_back(CH_0);
      q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
    end
    // mostly short literals, now and then long enough to saturate
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 6);
    if (flaw == 2) n = 0;
    repeat (n) begin
      d = hx ? $urandom_range(0, 15) : $urandom_range(0, 9);
      if (d < 10) q.push_back(CH_0 + 8'(d));
      else q.push_back(($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 8'(d - 10));
    end
    case (flaw)
      1: q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
      3: q.push_front($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      4: q.insert($urandom_range(0, q.size()), 8'h20);
      5: q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
      6: begin
        q.delete();
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin
    int goal;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty literal, each sign, both prefixes, malformed shapes
    send_beat(8'h00, 1'b0, 1'b1);
    foreach (probes[i]) send_lit(to_chars(probes[i]), 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h35, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_lit(to_chars("A"), 1'b0);
    drain();

    goal = chars_sent;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 26; recv_stall_pct = 82; end
        1: begin send_idle_pct = 82; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      goal += ITEM_TARGET / 3;
      while (chars_sent < goal) send_lit(make_literal(), 1'b1);
      // hold the sender until every literal so far has its result
      drain();
    end

    $display("tb: sent %0d characters in %0d literals; %0d results compared, %0d well formed",
             chars_sent, lits_sent, results_seen, well_formed);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/dhip_pkg.sv
hdl/dhip_core.sv
hdl/decimal_hex_integer_parser_top.sv
hdl/dhip_checker.sv
tb/sv/dhip_checker.sv
tb/sv/tb.sv
